### hdl/telnet_line_editor_assert.svh
// Assertion macros for the telnet line editor.
`ifndef TELNET_LINE_EDITOR_ASSERT_SVH
`define TELNET_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tle assertion failed");

// Next-cycle implication, disabled in reset.
`define TLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tle assertion failed");

`endif

### hdl/tle_pkg.sv
// Shared types and constants of the telnet line editor.
`default_nettype none

package tle_pkg;

  localparam int LINE_LEN_DEF = 32;

  localparam int Q_DEPTH = 2;
  localparam int QPW     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] BYTE_IAC   = 8'hFF;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_ERASE,
    OP_ENTER
  } tle_op_e;

  typedef struct packed {
    tle_op_e    op;
    logic [7:0] data;
  } tle_cmd_t;

endpackage

`default_nettype wire

### hdl/tle_if.sv
// Valid/ready channel interfaces for input bytes and result words.
`default_nettype none

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

`default_nettype wire

### hdl/telnet_line_editor.sv
// Top level of the telnet line editor.
`default_nettype none

// Telnet line editor. Bytes enter on byte_i and results leave on res_o as
// words of kind echo, line byte or end of line, with out_last on the final
// word of each input byte. Bytes that give at most one result (printable,
// IAC and its two following bytes, ignored codes) are taken one per cycle
// while the two-entry command queue has room. The back-end sequencer drives
// one result word per cycle through its output register while res_o is
// ready: an erase with echo gives BS, space, BS; an enter gives CR, LF with
// echo, then the line bytes and an end word with their count. The user sets
// echo by cfg_we_i/cfg_wdata_i while idle; the block does not enforce this.
module telnet_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  tle_in_if.sink    byte_i,
  tle_out_if.source res_o
);

  logic     push_valid, push_ready;
  tle_cmd_t push_cmd;
  logic     pop_valid, pop;
  tle_cmd_t pop_cmd;

  tle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  tle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  tle_back #(
    .LINE_LEN (LINE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

### hdl/tle_front.sv
// Front end: accepts bytes, drops telnet IAC sequences, classifies edit commands.
`default_nettype none

module tle_front
  import tle_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tle_in_if.sink     byte_i,
  input  wire logic  push_ready_i,
  output logic       push_valid_o,
  output tle_cmd_t   push_cmd_o
);

  logic [1:0] skip_q, skip_d;
  logic       accept;
  logic       cmd_ok;
  logic [7:0] b;

  assign byte_i.ready = push_ready_i;
  assign accept       = byte_i.valid && push_ready_i;
  assign b            = byte_i.in_byte;

  always_comb begin
    cmd_ok          = 1'b0;
    push_cmd_o.op   = OP_CHAR;
    push_cmd_o.data = b;
    if (b == BYTE_CR || b == BYTE_LF) begin
      cmd_ok        = 1'b1;
      push_cmd_o.op = OP_ENTER;
    end else if (b == BYTE_BS || b == BYTE_DEL) begin
      cmd_ok        = 1'b1;
      push_cmd_o.op = OP_ERASE;
    end else if (b >= BYTE_SPACE && b < BYTE_DEL) begin
      cmd_ok        = 1'b1;
      push_cmd_o.op = OP_CHAR;
    end
  end

  always_comb begin
    skip_d       = skip_q;
    push_valid_o = 1'b0;
    if (accept) begin
      if (skip_q != 2'd0) begin
        skip_d = skip_q - 2'd1;
      end else if (b == BYTE_IAC) begin
        skip_d = 2'd2;
      end else begin
        push_valid_o = cmd_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 2'd0;
    end else begin
      skip_q <= skip_d;
    end
  end

endmodule

`default_nettype wire

### hdl/tle_queue.sv
// Short command queue between front and back end.
`default_nettype none

module tle_queue
  import tle_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  input  wire tle_cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output tle_cmd_t      pop_cmd_o,
  input  wire logic     pop_i
);

  tle_cmd_t        entries_q [Q_DEPTH];
  logic [QPW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]  cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != QCW'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### hdl/tle_back.sv
// Back end: line store, fill count and result sequencer with output register.
`default_nettype none
`include "telnet_line_editor_assert.svh"

module tle_back
  import tle_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_wdata_i,
  input  wire logic     cmd_valid_i,
  input  wire tle_cmd_t cmd_i,
  output logic          cmd_pop_o,
  tle_out_if.source     res_o
);

  localparam int DEPTH = LINE_LEN - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(LINE_LEN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SP   = 3'd1;
  localparam logic [2:0] S_BS2  = 3'd2;
  localparam logic [2:0] S_LF   = 3'd3;
  localparam logic [2:0] S_LINE = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;

  logic [7:0]    line_store_q [DEPTH];
  logic [7:0]    rdata_q;
  logic          echo_q;
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW:0]   k_nx;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;
  logic          adv;
  logic          emit;
  logic [1:0]    e_kind;
  logic [7:0]    e_byte;
  logic          e_last;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;

  assign adv          = !out_valid_q || res_o.ready;
  assign k_nx         = {1'b0, k_q} + 1'b1;
  assign res_o.valid    = out_valid_q;
  assign res_o.out_kind = out_kind_q;
  assign res_o.out_byte = out_byte_q;
  assign res_o.out_last = out_last_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    emit      = 1'b0;
    e_kind    = KIND_ECHO;
    e_byte    = cmd_i.data;
    e_last    = 1'b0;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (adv && cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_CHAR: begin
              if (count_q < CW'(DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
                emit    = echo_q;
                e_last  = 1'b1;
              end
            end
            OP_ERASE: begin
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
                if (echo_q) begin
                  emit    = 1'b1;
                  e_byte  = BYTE_BS;
                  state_d = S_SP;
                end
              end
            end
            OP_ENTER: begin
              rd_en = 1'b1;
              k_d   = '0;
              if (echo_q) begin
                emit    = 1'b1;
                e_byte  = BYTE_CR;
                state_d = S_LF;
              end else begin
                state_d = (count_q != '0) ? S_LINE : S_END;
              end
            end
            default: ;
          endcase
        end
      end
      S_SP: begin
        if (adv) begin
          emit    = 1'b1;
          e_byte  = BYTE_SPACE;
          state_d = S_BS2;
        end
      end
      S_BS2: begin
        if (adv) begin
          emit    = 1'b1;
          e_byte  = BYTE_BS;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LF: begin
        if (adv) begin
          emit    = 1'b1;
          e_byte  = BYTE_LF;
          state_d = (count_q != '0) ? S_LINE : S_END;
        end
      end
      S_LINE: begin
        if (adv) begin
          emit   = 1'b1;
          e_kind = KIND_LINE;
          e_byte = rdata_q;
          if (k_nx < {1'b0, count_q}) begin
            k_d     = k_nx[CW-1:0];
            rd_en   = 1'b1;
            rd_addr = k_nx[AW-1:0];
          end else begin
            state_d = S_END;
          end
        end
      end
      S_END: begin
        if (adv) begin
          emit    = 1'b1;
          e_kind  = KIND_END;
          e_byte  = 8'(count_q);
          e_last  = 1'b1;
          count_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = adv ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      echo_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        echo_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_kind_q <= e_kind;
      out_byte_q <= e_byte;
      out_last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_store_q[count_q[AW-1:0]] <= cmd_i.data;
    end
    if (rd_en) begin
      rdata_q <= line_store_q[rd_addr];
    end
  end

  `TLE_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH))
  `TLE_ASSERT_NOW(a_line_index, clk_i, rst_ni, state_q == S_LINE, k_q < count_q)
  `TLE_ASSERT_NEXT(a_count_held, clk_i, rst_ni,
                   state_q != S_IDLE && state_q != S_END, $stable(count_q))
  `TLE_ASSERT_NOW(a_end_last, clk_i, rst_ni,
                  out_valid_q && out_kind_q == KIND_END, out_last_q)

endmodule

`default_nettype wire

### tb/telnet_line_editor_test.sv
// Self-checking testbench for the telnet line editor: byte stream in, echo and line words out.
`default_nettype none

module telnet_line_editor_test
  import tle_pkg::*;
();

  localparam int LINE_LEN = LINE_LEN_DEF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_word_t;

  class line_editor_scoreboard;
    result_word_t pending_words[$];
    logic [7:0]   line_bytes[0:63];
    logic [5:0]   fill;
    logic [1:0]   skip;
    logic         echo;
    int unsigned  room;
    int unsigned  fails;

    function new(int unsigned line_len);
      room  = line_len - 1;
      fill  = '0;
      skip  = '0;
      echo  = 1'b0;
      fails = 0;
    endfunction

    function void add_word(logic [1:0] kind, logic [7:0] data);
      result_word_t w;
      w.kind = kind;
      w.data = data;
      w.last = 1'b0;
      pending_words.push_back(w);
    endfunction

    // predicts the words caused by one accepted input byte
    function void take_byte(logic [7:0] ch);
      int unsigned  before_n;
      int unsigned  k;
      result_word_t w;
      before_n = pending_words.size();
      if (skip != 2'd0) begin
        skip = skip - 2'd1;
        return;
      end
      if (ch == BYTE_IAC) begin
        skip = 2'd2;
        return;
      end
      if (ch == BYTE_CR || ch == BYTE_LF) begin
        if (echo) begin
          add_word(KIND_ECHO, BYTE_CR);
          add_word(KIND_ECHO, BYTE_LF);
        end
        for (k = 0; k < fill; k++) add_word(KIND_LINE, line_bytes[k]);
        add_word(KIND_END, {2'b00, fill});
        fill = '0;
      end else if (ch == BYTE_BS || ch == BYTE_DEL) begin
        if (fill != 0) begin
          fill = fill - 6'd1;
          if (echo) begin
            add_word(KIND_ECHO, BYTE_BS);
            add_word(KIND_ECHO, BYTE_SPACE);
            add_word(KIND_ECHO, BYTE_BS);
          end
        end
      end else if (ch >= BYTE_SPACE && ch < BYTE_DEL) begin
        if (fill < room) begin
          line_bytes[fill] = ch;
          fill = fill + 6'd1;
          if (echo) add_word(KIND_ECHO, ch);
        end
      end
      if (pending_words.size() > before_n) begin
        w = pending_words.pop_back();
        w.last = 1'b1;
        pending_words.push_back(w);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_word(logic [1:0] kind, logic [7:0] data, logic last);
      result_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d byte %02h last %0d", kind, data, last));
        return;
      end
      w = pending_words.pop_front();
      if (kind !== w.kind) report($sformatf("kind %0d, want %0d", kind, w.kind));
      if (data !== w.data) report($sformatf("byte %02h, want %02h", data, w.data));
      if (last !== w.last) report($sformatf("last %0d, want %0d", last, w.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  tle_in_if  byte_if ();
  tle_out_if res_if ();

  telnet_line_editor #(
    .LINE_LEN(LINE_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_if),
    .res_o      (res_if)
  );

  line_editor_scoreboard editor = new(LINE_LEN);

  int unsigned burst_left = 0;
  int unsigned random_sent = 0;
  int unsigned sink_ticks = 0;
  int unsigned sink_mode = 0;
  int unsigned stall_left = 0;

  always #1 clk_i = ~clk_i;

  // receiver: accept words and stall on a changing pattern
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready)
      editor.check_word(res_if.out_kind, res_if.out_byte, res_if.out_last);
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (sink_ticks == 0) begin
        sink_ticks = $urandom_range(20, 150);
        sink_mode  = $urandom_range(0, 3);
      end
      sink_ticks--;
      case (sink_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 3) != 0);
        2: res_if.ready <= (sink_ticks % 3 == 0);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
          end else begin
            stall_left = $urandom_range(1, 8);
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    editor.take_byte(b);
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    burst_left = 0;
    while (editor.pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_echo(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    editor.echo = v;
  endtask

  // typed line with edits, telnet commands and noise, usually closed by enter
  task automatic send_line();
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    logic [7:0]  b;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 12);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 31);
      if (pick < 3) begin
        send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
      end else if (pick == 3) begin
        send_byte(BYTE_IAC);
        repeat (2) begin
          b = ($urandom_range(0, 3) == 0) ? BYTE_IAC : 8'($urandom_range(0, 255));
          send_byte(b);
        end
        random_sent += 2;
      end else if (pick == 4) begin
        b = $urandom_range(0, 1) ? 8'($urandom_range(128, 254)) : 8'($urandom_range(0, 31));
        send_byte(b);
      end else begin
        send_byte(8'($urandom_range(32, 126)));
      end
      random_sent++;
    end
    pick = $urandom_range(0, 7);
    if (pick < 3) send_byte(BYTE_CR);
    else if (pick < 6) send_byte(BYTE_LF);
    else if (pick == 6) begin
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
    end
    random_sent++;
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    int unsigned ph;
    int unsigned k;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.in_byte <= 8'h00;
    directed_bytes = '{BYTE_CR, 8'h41, BYTE_SPACE, 8'h7E, BYTE_DEL, BYTE_BS, BYTE_BS,
                       BYTE_BS, 8'h00, 8'h1F, 8'h80, 8'hFE, BYTE_IAC, BYTE_IAC, 8'h41,
                       BYTE_IAC, BYTE_CR, BYTE_LF, 8'h7A, BYTE_CR, BYTE_LF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_echo(1'b1);
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain();
    for (ph = 0; ph < 4; ph++) begin
      set_echo(ph[0]);
      random_sent = 0;
      while (random_sent < 90) begin
        if ($urandom_range(0, 5) == 0) begin
          for (k = 0; k < 5; k++) send_byte(8'($urandom_range(0, 255)));
          random_sent += 5;
        end else begin
          send_line();
        end
      end
      drain();
    end
    if (editor.pending_words.size() != 0)
      editor.report($sformatf("%0d words never arrived", editor.pending_words.size()));
    if (editor.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
